// ----- rtl/core/cdte_pkg.sv -----
// Shared widths, constants, microcode field codes and control types for the date converter.
`default_nettype none
package cdte_pkg;

  // Port field widths.
  localparam int YearW   = 12;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int HourW   = 5;
  localparam int MinuteW = 6;
  localparam int SecondW = 6;
  localparam int MillisW = 10;
  localparam int EpochW  = 46;

  // Internal widths.
  localparam int YrsW  = 13;  // biased year count, up to 4494
  localparam int DaysW = 21;  // day count from year one, biased by 400 years
  localparam int MulAW = 21;
  localparam int MulKW = 27;
  localparam int PcW   = 4;

  // Adder source codes.
  localparam logic [2:0] SRC_NONE   = 3'd0;
  localparam logic [2:0] SRC_YBLK   = 3'd1;
  localparam logic [2:0] SRC_MUL    = 3'd2;
  localparam logic [2:0] SRC_EPOCH  = 3'd3;
  localparam logic [2:0] SRC_MONTH  = 3'd4;
  localparam logic [2:0] SRC_DAY    = 3'd5;
  localparam logic [2:0] SRC_MILLIS = 3'd6;

  // Multiplier operand codes.
  localparam logic [2:0] MUL_R4   = 3'd0;
  localparam logic [2:0] MUL_R3   = 3'd1;
  localparam logic [2:0] MUL_DAYS = 3'd2;
  localparam logic [2:0] MUL_HOUR = 3'd3;
  localparam logic [2:0] MUL_MIN  = 3'd4;
  localparam logic [2:0] MUL_SEC  = 3'd5;

  // Jump condition codes.
  localparam logic [1:0] COND_NONE  = 2'd0;
  localparam logic [1:0] COND_YGE   = 2'd1;
  localparam logic [1:0] COND_MLOOP = 2'd2;

  typedef struct packed {
    logic           yk100;    // year block size: 1 selects 100, 0 selects 400
    logic           ystep;    // take one year block off when it fits
    logic [2:0]     add_src;
    logic           add_acc;  // adder writes the millisecond total, else the day count
    logic           mul_en;
    logic [2:0]     mul_sel;
    logic           m_step;
    logic [1:0]     cond;
    logic [PcW-1:0] target;
    logic           done;
  } ctl_word_t;

  typedef struct packed {
    logic yge;
    logic mloop;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/cdte_seq.sv -----
// Microcode sequencer: control store, step counter and conditional jumps.
`default_nettype none
module cdte_seq
  import cdte_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire logic      hold,
  input  wire dp_stat_t  stat,
  output ctl_word_t      cw,
  output logic           busy
);

  localparam logic [PcW-1:0] StepY400  = PcW'(0);
  localparam logic [PcW-1:0] StepY100  = PcW'(1);
  localparam logic [PcW-1:0] StepMonth = PcW'(6);

  logic [PcW-1:0] pc_r, pc_nxt;
  logic           busy_r, busy_nxt;
  logic           take;

  function automatic ctl_word_t ucode(input logic [PcW-1:0] pc);
    ctl_word_t w;
    w = '0;
    case (pc)
      PcW'(0): begin
        w.ystep = 1'b1; w.add_src = SRC_YBLK;
        w.cond = COND_YGE; w.target = StepY400;
      end
      PcW'(1): begin
        w.yk100 = 1'b1; w.ystep = 1'b1; w.add_src = SRC_YBLK;
        w.cond = COND_YGE; w.target = StepY100;
      end
      PcW'(2): begin
        w.mul_en = 1'b1; w.mul_sel = MUL_R4;
      end
      PcW'(3): begin
        w.add_src = SRC_MUL; w.mul_en = 1'b1; w.mul_sel = MUL_R3;
      end
      PcW'(4): begin
        w.add_src = SRC_MUL;
      end
      PcW'(5): begin
        w.add_src = SRC_EPOCH;
      end
      PcW'(6): begin
        w.add_src = SRC_MONTH; w.m_step = 1'b1;
        w.cond = COND_MLOOP; w.target = StepMonth;
      end
      PcW'(7): begin
        w.add_src = SRC_DAY;
      end
      PcW'(8): begin
        w.add_src = SRC_MILLIS; w.add_acc = 1'b1;
        w.mul_en = 1'b1; w.mul_sel = MUL_DAYS;
      end
      PcW'(9): begin
        w.add_src = SRC_MUL; w.add_acc = 1'b1;
        w.mul_en = 1'b1; w.mul_sel = MUL_HOUR;
      end
      PcW'(10): begin
        w.add_src = SRC_MUL; w.add_acc = 1'b1;
        w.mul_en = 1'b1; w.mul_sel = MUL_MIN;
      end
      PcW'(11): begin
        w.add_src = SRC_MUL; w.add_acc = 1'b1;
        w.mul_en = 1'b1; w.mul_sel = MUL_SEC;
      end
      PcW'(12): begin
        w.add_src = SRC_MUL; w.add_acc = 1'b1;
      end
      PcW'(13): begin
        w.done = 1'b1;
      end
      default: begin
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

  // An idle sequencer issues an all-zero word, which changes nothing in the datapath.
  assign cw   = busy_r ? ucode(pc_r) : '0;
  assign busy = busy_r;

  always_comb begin
    case (cw.cond)
      COND_NONE:  take = 1'b0;
      COND_YGE:   take = stat.yge;
      COND_MLOOP: take = stat.mloop;
      default:    take = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (start) begin
      pc_nxt   = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cw.done) begin
        if (!hold) begin
          busy_nxt = 1'b0;
        end
      end else if (take) begin
        pc_nxt = cw.target;
      end else begin
        pc_nxt = pc_r + PcW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/cdte_dp.sv -----
// Datapath: year block unit, month counter, shared adder and constant multiplier.
`default_nettype none
module cdte_dp
  import cdte_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               load,
  input  wire logic [YearW-1:0]   in_year,
  input  wire logic [MonthW-1:0]  in_month,
  input  wire logic [DayW-1:0]    in_day,
  input  wire logic [HourW-1:0]   in_hour,
  input  wire logic [MinuteW-1:0] in_minute,
  input  wire logic [SecondW-1:0] in_second,
  input  wire logic [MillisW-1:0] in_millis,
  input  wire ctl_word_t          cw,
  output dp_stat_t                stat,
  output logic [EpochW-1:0]       acc
);

  localparam logic [YearW-1:0]  EpochYear  = YearW'(1970);
  // The year is biased by one 400-year cycle less one so that year zero needs no borrow.
  localparam logic [YrsW-1:0]   YearBias   = YrsW'(399);
  localparam logic [YrsW-1:0]   Block400   = YrsW'(400);
  localparam logic [YrsW-1:0]   Block100   = YrsW'(100);
  localparam logic [YrsW-1:0]   LastOfCent = YrsW'(99);
  localparam logic [DaysW-1:0]  Days400    = DaysW'(146097);
  localparam logic [DaysW-1:0]  Days100    = DaysW'(36524);
  // Day count of the biased 1970-01-01.
  localparam logic [DaysW-1:0]  EpochDays  = DaysW'(865259);
  localparam logic [MulKW-1:0]  Days4      = MulKW'(1461);
  localparam logic [MulKW-1:0]  DaysYear   = MulKW'(365);
  localparam logic [MulKW-1:0]  MsDay      = MulKW'(86400000);
  localparam logic [MulKW-1:0]  MsHour     = MulKW'(3600000);
  localparam logic [MulKW-1:0]  MsMinute   = MulKW'(60000);
  localparam logic [MulKW-1:0]  MsSecond   = MulKW'(1000);
  localparam logic [MonthW-1:0] LastMonth  = MonthW'(12);

  logic [YrsW-1:0]    y_r;
  logic [1:0]         cent_r;
  logic               gt_r;
  logic [MonthW-1:0]  month_r, m_r;
  logic [DayW-1:0]    day_r;
  logic [HourW-1:0]   hour_r;
  logic [MinuteW-1:0] minute_r;
  logic [SecondW-1:0] second_r;
  logic [MillisW-1:0] millis_r;
  logic [DaysW-1:0]   days_r;
  logic [EpochW-1:0]  acc_r;
  logic [EpochW-1:0]  mul_r;

  logic [YrsW-1:0]          yk;
  logic                     yge, leap, mloop;
  logic [4:0]               mlen;
  logic [DayW-1:0]          dm1;
  logic [EpochW-1:0]        opa, opb, sum;
  logic [MulAW-1:0]         mula;
  logic [MulKW-1:0]         mulk;
  logic [MulAW+MulKW-1:0]   prod;

  function automatic logic [4:0] month_len(input logic [MonthW-1:0] m, input logic lp);
    case (m)
      MonthW'(1):  month_len = 5'd31;
      MonthW'(2):  month_len = lp ? 5'd29 : 5'd28;
      MonthW'(3):  month_len = 5'd31;
      MonthW'(4):  month_len = 5'd30;
      MonthW'(5):  month_len = 5'd31;
      MonthW'(6):  month_len = 5'd30;
      MonthW'(7):  month_len = 5'd31;
      MonthW'(8):  month_len = 5'd31;
      MonthW'(9):  month_len = 5'd30;
      MonthW'(10): month_len = 5'd31;
      MonthW'(11): month_len = 5'd30;
      MonthW'(12): month_len = 5'd31;
      default:     month_len = 5'd0;
    endcase
  endfunction

  assign yk  = cw.yk100 ? Block100 : Block400;
  assign yge = (y_r >= yk);

  // After both block loops y_r holds the biased year mod 100 and cent_r the
  // number of centuries taken, so the leap rule reads directly off them.
  assign leap = ((y_r[1:0] == 2'b11) && (y_r != LastOfCent)) ||
                ((y_r == LastOfCent) && (cent_r == 2'd3));

  assign mloop = (m_r < month_r) && (m_r <= LastMonth);
  assign mlen  = month_len(m_r, leap);
  assign dm1   = (day_r == '0) ? '0 : day_r - DayW'(1);

  always_comb begin
    opa = cw.add_acc ? acc_r : EpochW'(days_r);
    case (cw.add_src)
      SRC_NONE:   opb = '0;
      SRC_YBLK:   opb = yge ? EpochW'(cw.yk100 ? Days100 : Days400) : '0;
      SRC_MUL:    opb = mul_r;
      SRC_EPOCH: begin
        // Years up to 1970 contribute nothing; later ones drop the epoch offset.
        opb = gt_r ? EpochW'(DaysW'(~EpochDays + DaysW'(1))) : '0;
        if (!gt_r) begin
          opa = '0;
        end
      end
      SRC_MONTH:  opb = mloop ? EpochW'(mlen) : '0;
      SRC_DAY:    opb = EpochW'(dm1);
      SRC_MILLIS: opb = EpochW'(millis_r);
      default:    opb = '0;
    endcase
    sum = opa + opb;
  end

  always_comb begin
    case (cw.mul_sel)
      MUL_R4: begin
        mula = MulAW'(y_r[6:2]);
        mulk = Days4;
      end
      MUL_R3: begin
        mula = MulAW'(y_r[1:0]);
        mulk = DaysYear;
      end
      MUL_DAYS: begin
        mula = days_r;
        mulk = MsDay;
      end
      MUL_HOUR: begin
        mula = MulAW'(hour_r);
        mulk = MsHour;
      end
      MUL_MIN: begin
        mula = MulAW'(minute_r);
        mulk = MsMinute;
      end
      MUL_SEC: begin
        mula = MulAW'(second_r);
        mulk = MsSecond;
      end
      default: begin
        mula = '0;
        mulk = '0;
      end
    endcase
  end

  assign prod = mula * mulk;

  always_ff @(posedge clk) begin
    if (load) begin
      y_r      <= YrsW'(in_year) + YearBias;
      gt_r     <= (in_year > EpochYear);
      cent_r   <= 2'd0;
      month_r  <= in_month;
      m_r      <= MonthW'(1);
      day_r    <= in_day;
      hour_r   <= in_hour;
      minute_r <= in_minute;
      second_r <= in_second;
      millis_r <= in_millis;
      days_r   <= '0;
      acc_r    <= '0;
    end else begin
      if (cw.ystep && yge) begin
        y_r <= y_r - yk;
        if (cw.yk100) begin
          cent_r <= cent_r + 2'd1;
        end
      end
      if (cw.m_step && mloop) begin
        m_r <= m_r + MonthW'(1);
      end
      if (cw.add_src != SRC_NONE) begin
        if (cw.add_acc) begin
          acc_r <= sum;
        end else begin
          days_r <= sum[DaysW-1:0];
        end
      end
    end
    if (cw.mul_en) begin
      mul_r <= prod[EpochW-1:0];
    end
  end

  assign stat.yge   = yge;
  assign stat.mloop = mloop;
  assign acc        = acc_r;

endmodule
`default_nettype wire

// ----- rtl/core/civil_datetime_to_epoch_ms.sv -----
// Top level of the Gregorian date and time to epoch millisecond converter.
`default_nettype none
// Converts one broken-down Gregorian date and time (no time zone) into milliseconds
// since 1970-01-01 00:00:00.000. One item is worked on at a time: the block takes
// no new item until the result of the last one is registered, and goes idle in the
// same cycle. A microcoded sequencer drives one shared adder: it strips up to 11
// 400-year blocks and up to 3 100-year blocks from the year, adds the days of the
// remaining years from the multiplier, drops the epoch offset, then walks the whole
// months before the given one (up to 12, since month codes above twelve take all
// twelve real months), and finishes with a fixed tail that scales days, hours,
// minutes and seconds on one constant multiplier. The finished result sits in an
// output register, so a waiting result stalls the block only when the next one is done.
// Years up to 1970 contribute no whole-year days; fields are not range checked.
module civil_datetime_to_epoch_ms
  import cdte_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [YearW-1:0]   in_year,
  input  wire logic [MonthW-1:0]  in_month,
  input  wire logic [DayW-1:0]    in_day,
  input  wire logic [HourW-1:0]   in_hour,
  input  wire logic [MinuteW-1:0] in_minute,
  input  wire logic [SecondW-1:0] in_second,
  input  wire logic [MillisW-1:0] in_millis,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [EpochW-1:0]       out_epoch_ms
);

  ctl_word_t         cw;
  dp_stat_t          stat;
  logic              busy, start, hold, emit;
  logic [EpochW-1:0] acc;
  logic              out_valid_r;
  logic [EpochW-1:0] out_epoch_ms_r;

  assign in_stall = busy;
  assign start    = in_valid && !busy;
  // The last step waits while an earlier result has not been transferred.
  assign hold     = out_valid_r && out_stall;
  assign emit     = cw.done && !hold;

  cdte_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .hold  (hold),
    .stat  (stat),
    .cw    (cw),
    .busy  (busy)
  );

  cdte_dp u_dp (
    .clk       (clk),
    .load      (start),
    .in_year   (in_year),
    .in_month  (in_month),
    .in_day    (in_day),
    .in_hour   (in_hour),
    .in_minute (in_minute),
    .in_second (in_second),
    .in_millis (in_millis),
    .cw        (cw),
    .stat      (stat),
    .acc       (acc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_epoch_ms_r <= acc;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_epoch_ms = out_epoch_ms_r;

endmodule
`default_nettype wire

// ----- rtl/core/cdte_checker.sv -----
// Port-level assertions for the date converter and the bind that attaches them.
`default_nettype none
module cdte_checker
  import cdte_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [EpochW-1:0] out_epoch_ms
);

  // A transfer in starts the conversion, so the block is busy right after it.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input side not stalled after a transfer");

  // A new result only comes out of a conversion that was running.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a conversion in progress");

  // The block goes idle only by presenting its result.
  a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_stall) |-> out_valid)
    else $error("block went idle without a result");

  // A stalled result stays and holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_epoch_ms)))
    else $error("stalled result changed");

endmodule

bind civil_datetime_to_epoch_ms cdte_checker u_cdte_checker (.*);
`default_nettype wire
